/* hdl/ucsfs_pkg.sv */
package ucsfs_pkg;

   localparam int PAGE_BYTES  = 256;
   localparam int FRAME_BYTES = 8;
   localparam int PAGE_AW     = $clog2(PAGE_BYTES);
   localparam int FRAME_AW    = $clog2(FRAME_BYTES);
   localparam int WAIT_W      = 10;
   localparam int LEN_W       = 24;
   localparam int MAX_RES     = 4;
   localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
   localparam int RES_POS_W   = $clog2(MAX_RES);

   localparam logic [7:0] FLASH_READ      = 8'h03;
   localparam logic [7:0] FLASH_ERASE     = 8'h52;
   localparam logic [7:0] FLASH_PROGRAM   = 8'h02;
   localparam logic [7:0] FLASH_WREN      = 8'h06;
   localparam logic [7:0] FLASH_RDSR      = 8'h05;
   localparam logic [7:0] FLASH_DUMMY     = 8'h00;
   localparam int         SR_BUSY_BIT     = 0;
   localparam int         SR_WEL_BIT      = 1;

   localparam logic [7:0] CMD_READ        = 8'd114;
   localparam logic [7:0] CMD_ERASE       = 8'd101;
   localparam logic [7:0] CMD_PROGRAM     = 8'd119;
   localparam logic [7:0] CMD_FILL        = 8'd98;
   localparam logic [7:0] REPLY_READY     = 8'd114;
   localparam logic [7:0] REPLY_FILL      = 8'd98;

   localparam logic CSR_WEN_WAIT  = 1'b0;
   localparam logic CSR_POLL_WAIT = 1'b1;

   localparam logic [WAIT_W-1:0] WEN_WAIT_RESET  = 10'd10;
   localparam logic [WAIT_W-1:0] POLL_WAIT_RESET = 10'd1;

   typedef enum logic [1:0] {
      EV_UART = 2'd0,
      EV_SPI  = 2'd1,
      EV_TICK = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      ACT_SPI   = 2'd0,
      ACT_CSON  = 2'd1,
      ACT_CSOFF = 2'd2,
      ACT_UART  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      M_IDLE  = 3'd0,
      M_FILL  = 3'd1,
      M_READ  = 3'd2,
      M_ERASE = 3'd3,
      M_PROG  = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      P_WEN   = 4'd0,
      P_WWAIT = 4'd1,
      P_SCMD  = 4'd2,
      P_SDAT  = 4'd3,
      P_OPC   = 4'd4,
      P_A2    = 4'd5,
      P_A1    = 4'd6,
      P_A0    = 4'd7,
      P_DATA  = 4'd8,
      P_PWAIT = 4'd9,
      P_PCMD  = 4'd10,
      P_PDAT  = 4'd11
   } phase_type;

endpackage

/* hdl/ucsfs_ram.sv */
module ucsfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/uart_command_spi_flash_sequencer.sv */
// Command sequencer that drives an SPI NOR flash from UART command frames.
// The request channel carries one event per transfer: a received UART byte,
// the end of an SPI byte exchange with the byte read back, or a millisecond
// tick. Each event yields zero to three actions on the response channel
// (SPI exchange, chip select on, chip select off, UART send); rsp_last marks
// the final action caused by an event. Commands are eight-byte frames: read,
// block erase, page program and page store fill.
// An event is registered on acceptance in the input register and evaluated
// once the response register is free; its actions are then registered in
// the response register, from which the first is offered. One event is
// taken per cycle while the response register is free; an event with
// actions holds the response register until its last action is taken.
// When the receiver stalls, the pending actions hold and one further event
// waits in the input register; after that req_ready falls.
// Reset returns the sequencer to idle, empties both registers, restores the
// wait registers to ten and one ticks and makes the page store read as zero
// until it is first filled. The wait registers are written through csr_;
// the user must write them only while the sequencer is idle; the block
// itself does not enforce it.
module uart_command_spi_flash_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_action,
   output logic [7:0] rsp_value,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);

   localparam int PAGE_AW   = ucsfs_pkg::PAGE_AW;
   localparam int FRAME_AW  = ucsfs_pkg::FRAME_AW;
   localparam int WAIT_W    = ucsfs_pkg::WAIT_W;
   localparam int LEN_W     = ucsfs_pkg::LEN_W;
   localparam int MAX_RES   = ucsfs_pkg::MAX_RES;
   localparam int RES_CNT_W = ucsfs_pkg::RES_CNT_W;
   localparam int RES_POS_W = ucsfs_pkg::RES_POS_W;

   logic                  in_valid_ff;
   ucsfs_pkg::event_type  in_op_ff;
   logic [7:0]            in_data_ff;

   logic [WAIT_W-1:0]     wen_wait_ff;
   logic [WAIT_W-1:0]     poll_wait_ff;

   ucsfs_pkg::mode_type   mode_ff, mode_in;
   ucsfs_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]            frame_ff [ucsfs_pkg::FRAME_BYTES];
   logic [FRAME_AW-1:0]   frame_cnt_ff, frame_cnt_in;
   logic [PAGE_AW-1:0]    page_cnt_ff, page_cnt_in;
   logic [LEN_W-1:0]      byte_cnt_ff, byte_cnt_in;
   logic [WAIT_W-1:0]     wait_cnt_ff, wait_cnt_in;
   logic                  page_loaded_ff;

   ucsfs_pkg::action_type bnd_act_ff [MAX_RES];
   logic [7:0]            bnd_val_ff [MAX_RES];
   logic [RES_CNT_W-1:0]  bnd_cnt_ff;
   logic [RES_POS_W-1:0]  bnd_pos_ff;

   ucsfs_pkg::action_type res_act [MAX_RES];
   logic [7:0]            res_val [MAX_RES];
   logic [RES_CNT_W-1:0]  res_cnt;

   logic                  bundle_free;
   logic                  advance;
   logic                  busy_mode;
   logic                  fill_wr, fill_done;
   logic                  frame_wr, frame_done;
   logic                  spi_ev, tick_ev, tick_fire;
   logic [WAIT_W-1:0]     wait_dec;
   logic                  wen_zero, poll_zero;
   logic [LEN_W-1:0]      read_len;
   logic                  page_end;
   logic [PAGE_AW-1:0]    page_rd_addr;
   logic [7:0]            page_rd_raw;
   logic [7:0]            page_rd;

   // Transfer control.
   assign rsp_valid   = (bnd_cnt_ff != '0);
   assign rsp_last    = (RES_CNT_W'(bnd_pos_ff) + RES_CNT_W'(1) == bnd_cnt_ff);
   assign rsp_action  = bnd_act_ff[bnd_pos_ff];
   assign rsp_value   = bnd_val_ff[bnd_pos_ff];
   assign bundle_free = !rsp_valid || (rsp_ready && rsp_last);
   assign advance     = in_valid_ff && bundle_free;
   assign req_ready   = !in_valid_ff || bundle_free;

   // Event decode.
   assign busy_mode  = (mode_ff == ucsfs_pkg::M_READ) || (mode_ff == ucsfs_pkg::M_ERASE) ||
                       (mode_ff == ucsfs_pkg::M_PROG);
   assign fill_wr    = advance && (in_op_ff == ucsfs_pkg::EV_UART) &&
                       (mode_ff == ucsfs_pkg::M_FILL);
   assign fill_done  = fill_wr && (page_cnt_ff == PAGE_AW'(ucsfs_pkg::PAGE_BYTES - 1));
   assign frame_wr   = advance && (in_op_ff == ucsfs_pkg::EV_UART) &&
                       (mode_ff == ucsfs_pkg::M_IDLE);
   assign frame_done = frame_wr && (frame_cnt_ff == FRAME_AW'(ucsfs_pkg::FRAME_BYTES - 1));
   assign spi_ev     = advance && (in_op_ff == ucsfs_pkg::EV_SPI) && busy_mode;
   assign tick_ev    = advance && (in_op_ff == ucsfs_pkg::EV_TICK) &&
                       ((mode_ff == ucsfs_pkg::M_ERASE) || (mode_ff == ucsfs_pkg::M_PROG)) &&
                       ((phase_ff == ucsfs_pkg::P_WWAIT) || (phase_ff == ucsfs_pkg::P_PWAIT));
   assign wait_dec   = (wait_cnt_ff != '0) ? wait_cnt_ff - WAIT_W'(1) : wait_cnt_ff;
   assign tick_fire  = tick_ev && (wait_dec == '0);
   assign wen_zero   = (wen_wait_ff == '0);
   assign poll_zero  = (poll_wait_ff == '0);
   assign read_len   = {frame_ff[1], frame_ff[2], frame_ff[3]};
   assign page_end   = (byte_cnt_ff == LEN_W'(ucsfs_pkg::PAGE_BYTES - 1));
   assign page_rd    = page_loaded_ff ? page_rd_raw : 8'h00;

   // The page store is read ahead: its address follows the next state, so the
   // registered read data always matches the byte the current state will send.
   assign page_rd_addr = (phase_in == ucsfs_pkg::P_DATA) ?
                         byte_cnt_in[PAGE_AW-1:0] + PAGE_AW'(1) : '0;

   ucsfs_ram #(
      .WIDTH (8),
      .DEPTH (ucsfs_pkg::PAGE_BYTES)
   ) u_page_store (
      .clock   (clock),
      .wr_en   (fill_wr),
      .wr_addr (page_cnt_ff),
      .wr_data (in_data_ff),
      .rd_addr (page_rd_addr),
      .rd_data (page_rd_raw)
   );

   // Next state.
   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      frame_cnt_in = frame_cnt_ff;
      page_cnt_in  = page_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      wait_cnt_in  = wait_cnt_ff;

      if (fill_wr) begin
         page_cnt_in = page_cnt_ff + PAGE_AW'(1);
         if (fill_done) begin
            page_cnt_in = '0;
            mode_in     = ucsfs_pkg::M_IDLE;
            phase_in    = ucsfs_pkg::P_WEN;
         end
      end

      if (frame_wr) begin
         frame_cnt_in = frame_cnt_ff + FRAME_AW'(1);
         if (frame_done) begin
            frame_cnt_in = '0;
            case (frame_ff[0])
               ucsfs_pkg::CMD_FILL: begin
                  mode_in     = ucsfs_pkg::M_FILL;
                  page_cnt_in = '0;
               end
               ucsfs_pkg::CMD_READ: begin
                  mode_in  = ucsfs_pkg::M_READ;
                  phase_in = ucsfs_pkg::P_OPC;
               end
               ucsfs_pkg::CMD_ERASE: begin
                  mode_in  = ucsfs_pkg::M_ERASE;
                  phase_in = ucsfs_pkg::P_WEN;
               end
               ucsfs_pkg::CMD_PROGRAM: begin
                  mode_in  = ucsfs_pkg::M_PROG;
                  phase_in = ucsfs_pkg::P_WEN;
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end

      if (tick_ev) begin
         wait_cnt_in = wait_dec;
         if (tick_fire) begin
            phase_in = (phase_ff == ucsfs_pkg::P_WWAIT) ? ucsfs_pkg::P_SCMD : ucsfs_pkg::P_PCMD;
         end
      end

      if (spi_ev) begin
         case (phase_ff)
            ucsfs_pkg::P_WEN: begin
               wait_cnt_in = wen_wait_ff;
               phase_in    = wen_zero ? ucsfs_pkg::P_SCMD : ucsfs_pkg::P_WWAIT;
            end
            ucsfs_pkg::P_SCMD: begin
               phase_in = ucsfs_pkg::P_SDAT;
            end
            ucsfs_pkg::P_PCMD: begin
               phase_in = ucsfs_pkg::P_PDAT;
            end
            ucsfs_pkg::P_SDAT: begin
               if (!in_data_ff[ucsfs_pkg::SR_WEL_BIT]) begin
                  mode_in  = ucsfs_pkg::M_IDLE;
                  phase_in = ucsfs_pkg::P_WEN;
               end else begin
                  phase_in = ucsfs_pkg::P_OPC;
               end
            end
            ucsfs_pkg::P_OPC: begin
               phase_in = ucsfs_pkg::P_A2;
            end
            ucsfs_pkg::P_A2: begin
               phase_in = ucsfs_pkg::P_A1;
            end
            ucsfs_pkg::P_A1: begin
               phase_in = ucsfs_pkg::P_A0;
            end
            ucsfs_pkg::P_A0: begin
               if (mode_ff == ucsfs_pkg::M_READ) begin
                  byte_cnt_in = read_len;
                  if (read_len == '0) begin
                     mode_in  = ucsfs_pkg::M_IDLE;
                     phase_in = ucsfs_pkg::P_WEN;
                  end else begin
                     phase_in = ucsfs_pkg::P_DATA;
                  end
               end else if (mode_ff == ucsfs_pkg::M_ERASE) begin
                  wait_cnt_in = poll_wait_ff;
                  phase_in    = poll_zero ? ucsfs_pkg::P_PCMD : ucsfs_pkg::P_PWAIT;
               end else begin
                  byte_cnt_in = '0;
                  phase_in    = ucsfs_pkg::P_DATA;
               end
            end
            ucsfs_pkg::P_DATA: begin
               if (mode_ff == ucsfs_pkg::M_READ) begin
                  byte_cnt_in = byte_cnt_ff - LEN_W'(1);
                  if (byte_cnt_ff == LEN_W'(1)) begin
                     mode_in  = ucsfs_pkg::M_IDLE;
                     phase_in = ucsfs_pkg::P_WEN;
                  end
               end else begin
                  byte_cnt_in = byte_cnt_ff + LEN_W'(1);
                  if (page_end) begin
                     wait_cnt_in = poll_wait_ff;
                     phase_in    = poll_zero ? ucsfs_pkg::P_PCMD : ucsfs_pkg::P_PWAIT;
                  end
               end
            end
            ucsfs_pkg::P_PDAT: begin
               if (in_data_ff[ucsfs_pkg::SR_BUSY_BIT]) begin
                  wait_cnt_in = poll_wait_ff;
                  phase_in    = poll_zero ? ucsfs_pkg::P_PCMD : ucsfs_pkg::P_PWAIT;
               end else begin
                  mode_in  = ucsfs_pkg::M_IDLE;
                  phase_in = ucsfs_pkg::P_WEN;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Actions caused by the event in the input register.
   always_comb begin
      for (int i = 0; i < MAX_RES; i++) begin
         res_act[i] = ucsfs_pkg::ACT_SPI;
         res_val[i] = 8'h00;
      end
      res_cnt = '0;

      if (fill_done) begin
         res_act[0] = ucsfs_pkg::ACT_UART;
         res_val[0] = ucsfs_pkg::REPLY_READY;
         res_cnt    = RES_CNT_W'(1);
      end

      if (frame_done) begin
         case (frame_ff[0])
            ucsfs_pkg::CMD_FILL: begin
               res_act[0] = ucsfs_pkg::ACT_UART;
               res_val[0] = ucsfs_pkg::REPLY_FILL;
               res_cnt    = RES_CNT_W'(1);
            end
            ucsfs_pkg::CMD_READ: begin
               res_act[0] = ucsfs_pkg::ACT_CSON;
               res_val[1] = ucsfs_pkg::FLASH_READ;
               res_cnt    = RES_CNT_W'(2);
            end
            ucsfs_pkg::CMD_ERASE, ucsfs_pkg::CMD_PROGRAM: begin
               res_act[0] = ucsfs_pkg::ACT_CSON;
               res_val[1] = ucsfs_pkg::FLASH_WREN;
               res_cnt    = RES_CNT_W'(2);
            end
            default: begin
               res_cnt = '0;
            end
         endcase
      end

      if (tick_fire) begin
         res_act[0] = ucsfs_pkg::ACT_CSON;
         res_val[1] = ucsfs_pkg::FLASH_RDSR;
         res_cnt    = RES_CNT_W'(2);
      end

      if (spi_ev) begin
         case (phase_ff)
            ucsfs_pkg::P_WEN: begin
               res_act[0] = ucsfs_pkg::ACT_CSOFF;
               res_cnt    = RES_CNT_W'(1);
               if (wen_zero) begin
                  res_act[1] = ucsfs_pkg::ACT_CSON;
                  res_val[2] = ucsfs_pkg::FLASH_RDSR;
                  res_cnt    = RES_CNT_W'(3);
               end
            end
            ucsfs_pkg::P_SCMD, ucsfs_pkg::P_PCMD: begin
               res_val[0] = ucsfs_pkg::FLASH_DUMMY;
               res_cnt    = RES_CNT_W'(1);
            end
            ucsfs_pkg::P_SDAT: begin
               res_act[0] = ucsfs_pkg::ACT_CSOFF;
               if (!in_data_ff[ucsfs_pkg::SR_WEL_BIT]) begin
                  res_act[1] = ucsfs_pkg::ACT_UART;
                  res_val[1] = ucsfs_pkg::REPLY_READY;
                  res_cnt    = RES_CNT_W'(2);
               end else begin
                  res_act[1] = ucsfs_pkg::ACT_CSON;
                  res_val[2] = (mode_ff == ucsfs_pkg::M_ERASE) ?
                               ucsfs_pkg::FLASH_ERASE : ucsfs_pkg::FLASH_PROGRAM;
                  res_cnt    = RES_CNT_W'(3);
               end
            end
            ucsfs_pkg::P_OPC: begin
               res_val[0] = frame_ff[4];
               res_cnt    = RES_CNT_W'(1);
            end
            ucsfs_pkg::P_A2: begin
               res_val[0] = frame_ff[5];
               res_cnt    = RES_CNT_W'(1);
            end
            ucsfs_pkg::P_A1: begin
               res_val[0] = frame_ff[6];
               res_cnt    = RES_CNT_W'(1);
            end
            ucsfs_pkg::P_A0: begin
               if (mode_ff == ucsfs_pkg::M_READ) begin
                  if (read_len == '0) begin
                     res_act[0] = ucsfs_pkg::ACT_CSOFF;
                     res_act[1] = ucsfs_pkg::ACT_UART;
                     res_val[1] = ucsfs_pkg::REPLY_READY;
                     res_cnt    = RES_CNT_W'(2);
                  end else begin
                     res_val[0] = ucsfs_pkg::FLASH_DUMMY;
                     res_cnt    = RES_CNT_W'(1);
                  end
               end else if (mode_ff == ucsfs_pkg::M_ERASE) begin
                  res_act[0] = ucsfs_pkg::ACT_CSOFF;
                  res_cnt    = RES_CNT_W'(1);
                  if (poll_zero) begin
                     res_act[1] = ucsfs_pkg::ACT_CSON;
                     res_val[2] = ucsfs_pkg::FLASH_RDSR;
                     res_cnt    = RES_CNT_W'(3);
                  end
               end else begin
                  res_val[0] = page_rd;
                  res_cnt    = RES_CNT_W'(1);
               end
            end
            ucsfs_pkg::P_DATA: begin
               if (mode_ff == ucsfs_pkg::M_READ) begin
                  res_act[0] = ucsfs_pkg::ACT_UART;
                  res_val[0] = in_data_ff;
                  if (byte_cnt_ff == LEN_W'(1)) begin
                     res_act[1] = ucsfs_pkg::ACT_CSOFF;
                     res_act[2] = ucsfs_pkg::ACT_UART;
                     res_val[2] = ucsfs_pkg::REPLY_READY;
                     res_cnt    = RES_CNT_W'(3);
                  end else begin
                     res_val[1] = ucsfs_pkg::FLASH_DUMMY;
                     res_cnt    = RES_CNT_W'(2);
                  end
               end else if (page_end) begin
                  res_act[0] = ucsfs_pkg::ACT_CSOFF;
                  res_cnt    = RES_CNT_W'(1);
                  if (poll_zero) begin
                     res_act[1] = ucsfs_pkg::ACT_CSON;
                     res_val[2] = ucsfs_pkg::FLASH_RDSR;
                     res_cnt    = RES_CNT_W'(3);
                  end
               end else begin
                  res_val[0] = page_rd;
                  res_cnt    = RES_CNT_W'(1);
               end
            end
            ucsfs_pkg::P_PDAT: begin
               res_act[0] = ucsfs_pkg::ACT_CSOFF;
               if (in_data_ff[ucsfs_pkg::SR_BUSY_BIT]) begin
                  res_cnt = RES_CNT_W'(1);
                  if (poll_zero) begin
                     res_act[1] = ucsfs_pkg::ACT_CSON;
                     res_val[2] = ucsfs_pkg::FLASH_RDSR;
                     res_cnt    = RES_CNT_W'(3);
                  end
               end else begin
                  res_act[1] = ucsfs_pkg::ACT_UART;
                  res_val[1] = ucsfs_pkg::REPLY_READY;
                  res_cnt    = RES_CNT_W'(2);
               end
            end
            default: begin
               res_cnt = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         wen_wait_ff    <= ucsfs_pkg::WEN_WAIT_RESET;
         poll_wait_ff   <= ucsfs_pkg::POLL_WAIT_RESET;
         mode_ff        <= ucsfs_pkg::M_IDLE;
         phase_ff       <= ucsfs_pkg::P_WEN;
         frame_cnt_ff   <= '0;
         page_cnt_ff    <= '0;
         byte_cnt_ff    <= '0;
         wait_cnt_ff    <= '0;
         page_loaded_ff <= 1'b0;
         bnd_cnt_ff     <= '0;
         bnd_pos_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end

         if (csr_we) begin
            case (csr_index)
               ucsfs_pkg::CSR_WEN_WAIT: begin
                  wen_wait_ff <= csr_wdata;
               end
               ucsfs_pkg::CSR_POLL_WAIT: begin
                  poll_wait_ff <= csr_wdata;
               end
               default: begin
                  wen_wait_ff <= wen_wait_ff;
               end
            endcase
         end

         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         frame_cnt_ff <= frame_cnt_in;
         page_cnt_ff  <= page_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         wait_cnt_ff  <= wait_cnt_in;

         if (fill_wr) begin
            page_loaded_ff <= 1'b1;
         end

         if (advance) begin
            bnd_cnt_ff <= res_cnt;
            bnd_pos_ff <= '0;
         end else if (rsp_valid && rsp_ready) begin
            if (rsp_last) begin
               bnd_cnt_ff <= '0;
               bnd_pos_ff <= '0;
            end else begin
               bnd_pos_ff <= bnd_pos_ff + RES_POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= ucsfs_pkg::event_type'(req_op);
         in_data_ff <= req_data;
      end
      if (frame_wr) begin
         frame_ff[frame_cnt_ff] <= in_data_ff;
      end
      if (advance) begin
         for (int i = 0; i < MAX_RES; i++) begin
            bnd_act_ff[i] <= res_act[i];
            bnd_val_ff[i] <= res_val[i];
         end
      end
   end

endmodule

/* dv/tb_uart_command_spi_flash_sequencer.sv */
`timescale 1ns / 1ps

module tb_uart_command_spi_flash_sequencer;

   localparam int WAIT_W      = ucsfs_pkg::WAIT_W;
   localparam int LEN_W       = ucsfs_pkg::LEN_W;
   localparam int MAX_RES     = ucsfs_pkg::MAX_RES;
   localparam int PAGE_BYTES  = ucsfs_pkg::PAGE_BYTES;
   localparam int FRAME_BYTES = ucsfs_pkg::FRAME_BYTES;
   localparam int PAGE_AW     = ucsfs_pkg::PAGE_AW;
   localparam int FRAME_AW    = ucsfs_pkg::FRAME_AW;

   localparam logic [1:0] EV_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [WAIT_W-1:0]            wen_wait;
      logic [WAIT_W-1:0]            poll_wait;
      ucsfs_pkg::mode_type          mode;
      ucsfs_pkg::phase_type         phase;
      logic [FRAME_BYTES-1:0][7:0]  frame;
      logic [3:0]                   frame_cnt;
      logic [PAGE_BYTES-1:0][7:0]   page;
      logic [8:0]                   page_cnt;
      logic [LEN_W-1:0]             byte_cnt;
      logic [WAIT_W-1:0]            wait_cnt;
   } flash_state_type;

   typedef struct packed {
      ucsfs_pkg::action_type action;
      logic [7:0]            value;
      logic                  last;
   } flash_action_type;

   typedef struct packed {
      logic [2:0]                       count;
      flash_action_type [MAX_RES-1:0]   item;
   } flash_out_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } flash_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_op = 2'd0;
   logic [7:0] req_data = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_action;
   logic [7:0] rsp_value;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [9:0] csr_wdata = 10'd0;

   flash_state_type  seen_flash;
   flash_state_type  planned_flash;
   flash_event_type  pending_events[$];
   flash_action_type expected_actions[$];
   int               queued_count = 0;
   int               failures = 0;
   int               busy_one_in = 3;
   int               req_gap = 0;
   int               rsp_stall = 0;
   int               idle_cycles = 0;
   bit               req_burst = 1'b0;
   bit               rsp_burst = 1'b0;

   uart_command_spi_flash_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_action (rsp_action),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic flash_state_type reset_state();
      flash_state_type s;
      s = '0;
      s.wen_wait = ucsfs_pkg::WEN_WAIT_RESET;
      s.poll_wait = ucsfs_pkg::POLL_WAIT_RESET;
      s.mode = ucsfs_pkg::M_IDLE;
      s.phase = ucsfs_pkg::P_WEN;
      return s;
   endfunction

   task automatic add_action(inout flash_out_type o, input ucsfs_pkg::action_type a,
                             input logic [7:0] v);
      o.item[o.count[1:0]].action = a;
      o.item[o.count[1:0]].value = v;
      o.item[o.count[1:0]].last = 1'b0;
      o.count = o.count + 3'd1;
   endtask

   task automatic end_command(inout flash_state_type s, inout flash_out_type o);
      add_action(o, ucsfs_pkg::ACT_UART, ucsfs_pkg::REPLY_READY);
      s.mode = ucsfs_pkg::M_IDLE;
      s.phase = ucsfs_pkg::P_WEN;
   endtask

   task automatic start_status_read(inout flash_state_type s, inout flash_out_type o,
                                    input ucsfs_pkg::phase_type next_phase);
      add_action(o, ucsfs_pkg::ACT_CSON, 8'h00);
      add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_RDSR);
      s.phase = next_phase;
   endtask

   task automatic start_poll(inout flash_state_type s, inout flash_out_type o);
      s.wait_cnt = s.poll_wait;
      if (s.wait_cnt == '0) begin
         start_status_read(s, o, ucsfs_pkg::P_PCMD);
      end else begin
         s.phase = ucsfs_pkg::P_PWAIT;
      end
   endtask

   task automatic flash_step(inout flash_state_type s, input logic [1:0] op,
                             input logic [7:0] d, output flash_out_type o);
      o = '0;
      case (op)
         ucsfs_pkg::EV_UART: begin
            if (s.mode == ucsfs_pkg::M_FILL) begin
               s.page[s.page_cnt[PAGE_AW-1:0]] = d;
               s.page_cnt = s.page_cnt + 9'd1;
               if (s.page_cnt >= PAGE_BYTES) begin
                  s.page_cnt = '0;
                  end_command(s, o);
               end
            end else if (s.mode == ucsfs_pkg::M_IDLE) begin
               s.frame[s.frame_cnt[FRAME_AW-1:0]] = d;
               s.frame_cnt = s.frame_cnt + 4'd1;
               if (s.frame_cnt >= FRAME_BYTES) begin
                  s.frame_cnt = '0;
                  case (s.frame[0])
                     ucsfs_pkg::CMD_FILL: begin
                        s.mode = ucsfs_pkg::M_FILL;
                        s.page_cnt = '0;
                        add_action(o, ucsfs_pkg::ACT_UART, ucsfs_pkg::REPLY_FILL);
                     end
                     ucsfs_pkg::CMD_READ: begin
                        s.mode = ucsfs_pkg::M_READ;
                        s.phase = ucsfs_pkg::P_OPC;
                        add_action(o, ucsfs_pkg::ACT_CSON, 8'h00);
                        add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_READ);
                     end
                     ucsfs_pkg::CMD_ERASE, ucsfs_pkg::CMD_PROGRAM: begin
                        if (s.frame[0] == ucsfs_pkg::CMD_ERASE) begin
                           s.mode = ucsfs_pkg::M_ERASE;
                        end else begin
                           s.mode = ucsfs_pkg::M_PROG;
                        end
                        s.phase = ucsfs_pkg::P_WEN;
                        add_action(o, ucsfs_pkg::ACT_CSON, 8'h00);
                        add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_WREN);
                     end
                     default: ;
                  endcase
               end
            end
         end
         ucsfs_pkg::EV_SPI: begin
            if (s.mode == ucsfs_pkg::M_READ || s.mode == ucsfs_pkg::M_ERASE ||
                s.mode == ucsfs_pkg::M_PROG) begin
               case (s.phase)
                  ucsfs_pkg::P_WEN: begin
                     add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                     s.wait_cnt = s.wen_wait;
                     if (s.wait_cnt == '0) begin
                        start_status_read(s, o, ucsfs_pkg::P_SCMD);
                     end else begin
                        s.phase = ucsfs_pkg::P_WWAIT;
                     end
                  end
                  ucsfs_pkg::P_SCMD: begin
                     add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_DUMMY);
                     s.phase = ucsfs_pkg::P_SDAT;
                  end
                  ucsfs_pkg::P_PCMD: begin
                     add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_DUMMY);
                     s.phase = ucsfs_pkg::P_PDAT;
                  end
                  ucsfs_pkg::P_SDAT: begin
                     add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                     if (!d[ucsfs_pkg::SR_WEL_BIT]) begin
                        end_command(s, o);
                     end else begin
                        add_action(o, ucsfs_pkg::ACT_CSON, 8'h00);
                        add_action(o, ucsfs_pkg::ACT_SPI,
                                   (s.mode == ucsfs_pkg::M_ERASE) ? ucsfs_pkg::FLASH_ERASE
                                                                  : ucsfs_pkg::FLASH_PROGRAM);
                        s.phase = ucsfs_pkg::P_OPC;
                     end
                  end
                  ucsfs_pkg::P_OPC: begin
                     add_action(o, ucsfs_pkg::ACT_SPI, s.frame[4]);
                     s.phase = ucsfs_pkg::P_A2;
                  end
                  ucsfs_pkg::P_A2: begin
                     add_action(o, ucsfs_pkg::ACT_SPI, s.frame[5]);
                     s.phase = ucsfs_pkg::P_A1;
                  end
                  ucsfs_pkg::P_A1: begin
                     add_action(o, ucsfs_pkg::ACT_SPI, s.frame[6]);
                     s.phase = ucsfs_pkg::P_A0;
                  end
                  ucsfs_pkg::P_A0: begin
                     if (s.mode == ucsfs_pkg::M_READ) begin
                        s.byte_cnt = {s.frame[1], s.frame[2], s.frame[3]};
                        if (s.byte_cnt == '0) begin
                           add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                           end_command(s, o);
                        end else begin
                           add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_DUMMY);
                           s.phase = ucsfs_pkg::P_DATA;
                        end
                     end else if (s.mode == ucsfs_pkg::M_ERASE) begin
                        add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                        start_poll(s, o);
                     end else begin
                        s.byte_cnt = '0;
                        add_action(o, ucsfs_pkg::ACT_SPI, s.page[0]);
                        s.phase = ucsfs_pkg::P_DATA;
                     end
                  end
                  ucsfs_pkg::P_DATA: begin
                     if (s.mode == ucsfs_pkg::M_READ) begin
                        add_action(o, ucsfs_pkg::ACT_UART, d);
                        s.byte_cnt = s.byte_cnt - 24'd1;
                        if (s.byte_cnt == '0) begin
                           add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                           end_command(s, o);
                        end else begin
                           add_action(o, ucsfs_pkg::ACT_SPI, ucsfs_pkg::FLASH_DUMMY);
                        end
                     end else begin
                        s.byte_cnt = s.byte_cnt + 24'd1;
                        if (s.byte_cnt >= PAGE_BYTES) begin
                           add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                           start_poll(s, o);
                        end else begin
                           add_action(o, ucsfs_pkg::ACT_SPI,
                                      s.page[s.byte_cnt[PAGE_AW-1:0]]);
                        end
                     end
                  end
                  ucsfs_pkg::P_PDAT: begin
                     add_action(o, ucsfs_pkg::ACT_CSOFF, 8'h00);
                     if (d[ucsfs_pkg::SR_BUSY_BIT]) begin
                        start_poll(s, o);
                     end else begin
                        end_command(s, o);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ucsfs_pkg::EV_TICK: begin
            if ((s.mode == ucsfs_pkg::M_ERASE || s.mode == ucsfs_pkg::M_PROG) &&
                (s.phase == ucsfs_pkg::P_WWAIT || s.phase == ucsfs_pkg::P_PWAIT)) begin
               if (s.wait_cnt != '0) begin
                  s.wait_cnt = s.wait_cnt - 10'd1;
               end
               if (s.wait_cnt == '0) begin
                  if (s.phase == ucsfs_pkg::P_WWAIT) begin
                     start_status_read(s, o, ucsfs_pkg::P_SCMD);
                  end else begin
                     start_status_read(s, o, ucsfs_pkg::P_PCMD);
                  end
               end
            end
         end
         default: ;
      endcase
      if (o.count != 3'd0) begin
         o.item[o.count[1:0] - 2'd1].last = 1'b1;
      end
   endtask

   // The planned copy of the sequencer state lets the stimulus follow each command to its end.
   task automatic queue_event(input logic [1:0] op, input logic [7:0] data);
      flash_out_type ignored;
      flash_step(planned_flash, op, data, ignored);
      pending_events.push_back('{op: op, data: data});
      queued_count = queued_count + 1;
   endtask

   task automatic run_command();
      logic [7:0] b;
      while (planned_flash.mode != ucsfs_pkg::M_IDLE) begin
         b = 8'($urandom);
         if ($urandom_range(0, 24) == 0) begin
            queue_event(2'($urandom_range(0, 3)), b);
         end else if (planned_flash.mode == ucsfs_pkg::M_FILL) begin
            queue_event(ucsfs_pkg::EV_UART, b);
         end else if (planned_flash.phase == ucsfs_pkg::P_WWAIT ||
                      planned_flash.phase == ucsfs_pkg::P_PWAIT) begin
            queue_event(ucsfs_pkg::EV_TICK, b);
         end else begin
            if (planned_flash.phase == ucsfs_pkg::P_SDAT) begin
               b[ucsfs_pkg::SR_WEL_BIT] = ($urandom_range(0, 7) != 0);
            end else if (planned_flash.phase == ucsfs_pkg::P_PDAT) begin
               b[ucsfs_pkg::SR_BUSY_BIT] = (busy_one_in != 0) &&
                                           ($urandom_range(1, busy_one_in) == 1);
            end
            queue_event(ucsfs_pkg::EV_SPI, b);
         end
      end
   endtask

   task automatic queue_frame(input logic [7:0] cmd, input logic [23:0] len,
                              input logic [23:0] addr);
      run_command();
      while (planned_flash.frame_cnt != 4'd0) begin
         queue_event(ucsfs_pkg::EV_UART, 8'h00);
         run_command();
      end
      queue_event(ucsfs_pkg::EV_UART, cmd);
      queue_event(ucsfs_pkg::EV_UART, len[23:16]);
      queue_event(ucsfs_pkg::EV_UART, len[15:8]);
      queue_event(ucsfs_pkg::EV_UART, len[7:0]);
      queue_event(ucsfs_pkg::EV_UART, addr[23:16]);
      queue_event(ucsfs_pkg::EV_UART, addr[15:8]);
      queue_event(ucsfs_pkg::EV_UART, addr[7:0]);
      queue_event(ucsfs_pkg::EV_UART, 8'($urandom));
   endtask

   task automatic issue_command(input logic [7:0] cmd, input logic [23:0] len,
                                input logic [23:0] addr);
      queue_frame(cmd, len, addr);
      run_command();
   endtask

   task automatic queue_random_traffic(input int n);
      int         stop_at;
      int         pick;
      logic [7:0] cmd;
      logic [23:0] len;
      stop_at = queued_count + n;
      while (queued_count < stop_at) begin
         pick = $urandom_range(0, 15);
         len = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(7, 20))
                                           : 24'($urandom_range(0, 6));
         if (pick < 7) begin
            issue_command(ucsfs_pkg::CMD_READ, len, 24'($urandom));
         end else if (pick < 12) begin
            issue_command(ucsfs_pkg::CMD_ERASE, 24'($urandom), 24'($urandom));
         end else if (pick < 14) begin
            cmd = 8'($urandom);
            while (cmd == ucsfs_pkg::CMD_READ || cmd == ucsfs_pkg::CMD_ERASE ||
                   cmd == ucsfs_pkg::CMD_PROGRAM || cmd == ucsfs_pkg::CMD_FILL) begin
               cmd = 8'($urandom);
            end
            queue_frame(cmd, 24'($urandom), 24'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) queue_event(2'($urandom_range(0, 3)), 8'($urandom));
         end
      end
   endtask

   task automatic drain();
      while (pending_events.size() != 0 || req_valid || expected_actions.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_waits(input logic [WAIT_W-1:0] wen, input logic [WAIT_W-1:0] poll);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= ucsfs_pkg::CSR_WEN_WAIT;
      csr_wdata <= wen;
      @(posedge clock);
      csr_index <= ucsfs_pkg::CSR_POLL_WAIT;
      csr_wdata <= poll;
      @(posedge clock);
      csr_we <= 1'b0;
      seen_flash.wen_wait = wen;
      seen_flash.poll_wait = poll;
      planned_flash.wen_wait = wen;
      planned_flash.poll_wait = poll;
   endtask

   always @(posedge clock) begin : drive_events
      flash_out_type   predicted;
      flash_event_type next_event;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            flash_step(seen_flash, req_op, req_data, predicted);
            for (int i = 0; i < MAX_RES; i++) begin
               if (i < int'(predicted.count)) begin
                  expected_actions.push_back(predicted.item[i]);
               end
            end
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               next_event = pending_events.pop_front();
               req_valid <= 1'b1;
               req_op <= next_event.op;
               req_data <= next_event.data;
               if ($urandom_range(0, 15) == 0) begin
                  req_burst = !req_burst;
               end
               req_gap = req_burst ? 0 : int'($urandom_range(0, 11));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_actions
      flash_action_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_actions.size() == 0) begin
               $error("rsp_action: no transfer expected, actual %0d (value %0d)",
                      rsp_action, rsp_value);
               failures = failures + 1;
            end else begin
               want = expected_actions.pop_front();
               if (rsp_action !== want.action) begin
                  $error("rsp_action: expected %0d, actual %0d", want.action, rsp_action);
                  failures = failures + 1;
               end
               if (rsp_value !== want.value) begin
                  $error("rsp_value: expected %0d, actual %0d", want.value, rsp_value);
                  failures = failures + 1;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0d, actual %0d", want.last, rsp_last);
                  failures = failures + 1;
               end
            end
            if ($urandom_range(0, 15) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_stall = rsp_burst ? 0 : int'($urandom_range(0, 11));
         end
         if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      seen_flash = reset_state();
      planned_flash = reset_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Events that are not awaited, an unknown command, a zero-length read during which
      // a stray UART byte must be dropped, and an erase.
      queue_event(EV_UNUSED, 8'hFF);
      queue_event(ucsfs_pkg::EV_TICK, 8'h00);
      queue_event(ucsfs_pkg::EV_SPI, 8'hAA);
      queue_frame(8'hFF, 24'hFFFFFF, 24'hFFFFFF);
      queue_frame(ucsfs_pkg::CMD_READ, 24'h000000, 24'h000000);
      queue_event(ucsfs_pkg::EV_UART, ucsfs_pkg::CMD_READ);
      repeat (4) queue_event(ucsfs_pkg::EV_SPI, 8'hFF);
      issue_command(ucsfs_pkg::CMD_ERASE, 24'h000000, 24'($urandom));
      drain();

      write_waits(10'd0, 10'd0);
      busy_one_in = 3;
      queue_random_traffic(60);
      drain();

      write_waits(10'd1023, 10'd1023);
      busy_one_in = 0;
      issue_command(ucsfs_pkg::CMD_ERASE, 24'($urandom), 24'($urandom));
      drain();

      write_waits(10'($urandom_range(1, 4)), 10'($urandom_range(0, 3)));
      busy_one_in = 3;
      issue_command(ucsfs_pkg::CMD_FILL, 24'($urandom), 24'($urandom));
      issue_command(ucsfs_pkg::CMD_PROGRAM, 24'($urandom), 24'($urandom));
      queue_random_traffic(60);
      drain();

      write_waits(10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)));
      queue_random_traffic(50);
      drain();

      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
